// ----- rtl/bsfd_pkg.sv -----
// Shared types, constants and the field descriptor table of the battery-monitor
// status frame decoder. No dependencies.
`default_nettype none
package bsfd_pkg;

  localparam int unsigned FRAME_LEN   = 58;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned LAST_BYTE   = FRAME_LEN - 1;
  localparam int unsigned NUM_FIELDS  = 20;

  localparam logic [4:0]  LAST_FIELD     = 5'(NUM_FIELDS - 1);
  localparam logic [5:0]  LAST_BYTE_IDX  = 6'(LAST_BYTE);
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [16:0] ELAPSED_MAX    = 17'h1FFFF;
  localparam logic [27:0] TEMP_OFFSET    = 28'd232000;
  localparam logic [7:0]  SIGN_ZERO      = 8'h58;  // 'X'
  localparam logic [7:0]  SIGN_MINUS     = 8'h2D;  // '-'
  localparam logic [7:0]  FLAG_MASK      = 8'h7F;

  localparam logic [9:0]  SCALE_ONE      = 10'd1;
  localparam logic [9:0]  SCALE_VOLT     = 10'd5;
  localparam logic [9:0]  SCALE_CAP      = 10'd100;
  localparam logic [9:0]  SCALE_CUR      = 10'd125;
  localparam logic [9:0]  SCALE_TEMP     = 10'd857;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TIMEOUT = 2'd1,
    STAT_CSUM    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_RAW    = 3'd0,
    K_VOLT   = 3'd1,
    K_CAP    = 3'd2,
    K_CUR    = 3'd3,
    K_TEMP   = 3'd4,
    K_FLAG   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;  // first byte, big-endian
    logic [1:0]        len;   // number of bytes, 1 to 3
    kind_t             kind;
  } field_desc_t;

  function automatic field_desc_t field_desc(input logic [4:0] id);
    field_desc_t d;
    unique case (id)
      5'd0:    d = '{6'd25, 2'd1, K_RAW};
      5'd1:    d = '{6'd51, 2'd2, K_VOLT};
      5'd2:    d = '{6'd53, 2'd2, K_VOLT};
      5'd3:    d = '{6'd55, 2'd2, K_VOLT};
      5'd4:    d = '{6'd40, 2'd1, K_RAW};
      5'd5:    d = '{6'd0,  2'd3, K_VOLT};
      5'd6:    d = '{6'd9,  2'd3, K_CUR};
      5'd7:    d = '{6'd3,  2'd3, K_CUR};
      5'd8:    d = '{6'd6,  2'd3, K_CUR};
      5'd9:    d = '{6'd49, 2'd2, K_CAP};
      5'd10:   d = '{6'd34, 2'd3, K_RAW};
      5'd11:   d = '{6'd12, 2'd2, K_VOLT};
      5'd12:   d = '{6'd14, 2'd1, K_RAW};
      5'd13:   d = '{6'd15, 2'd2, K_VOLT};
      5'd14:   d = '{6'd17, 2'd1, K_RAW};
      5'd15:   d = '{6'd18, 2'd2, K_TEMP};
      5'd16:   d = '{6'd20, 2'd1, K_RAW};
      5'd17:   d = '{6'd21, 2'd2, K_TEMP};
      5'd18:   d = '{6'd23, 2'd1, K_RAW};
      5'd19:   d = '{6'd30, 2'd1, K_FLAG};
      default: d = '{6'd0,  2'd1, K_RAW};
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bms_status_frame_decoder.sv -----
// Top level of the battery-monitor status frame decoder: byte collection, timer,
// checksum, and the field readout sequencer. Uses bsfd_pkg and bsfd_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in_     | input     | in_valid / in_stall   | operation, data_byte
//   out_    | output    | out_valid / out_stall | status, field_id, value, last
//   cfg_    | input     | cfg_wr_en             | cfg_wr_data (timeout_ticks)
//
// After a good frame the sequencer reads the frame store through its one read
// port, field by field: ST_READ reads each byte of the field, ST_LAST shifts in
// the last byte read, and ST_EMIT writes the output register; in_stall stays
// high meanwhile. Output stalls hold the output register and stall the input.
// Reset is synchronous; the frame store needs no clearing.
`default_nettype none
module bms_status_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [4:0]       out_field_id,
  output logic [27:0]      out_value,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LAST = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [15:0]                  timeout_r;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic [16:0]                  el_r, el_nxt, el_inc;
  logic [4:0]                   fld_r, fld_nxt;
  logic [1:0]                   j_r, j_nxt;
  logic [23:0]                  acc_r, acc_nxt;
  logic                         rd_pend_r, rd_pend_nxt;

  logic                         out_valid_r, out_valid_nxt;
  bsfd_pkg::status_t            out_status_r, out_status_nxt;
  logic [4:0]                   out_field_id_r, out_field_id_nxt;
  logic [27:0]                  out_value_r, out_value_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_acc, out_free;
  logic                         ram_we, ram_re;
  logic [bsfd_pkg::ADDR_W-1:0]  ram_raddr;
  logic [7:0]                   ram_rdata;
  bsfd_pkg::field_desc_t        desc;

  logic [23:0]                  mul_in;
  logic [9:0]                   mul_k;
  logic [33:0]                  prod;
  logic [27:0]                  scaled, field_val;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && (in_operation == bsfd_pkg::OP_BYTE);
  assign ram_re   = (state_r == ST_READ);

  assign desc      = bsfd_pkg::field_desc(fld_r);
  assign ram_raddr = desc.addr + {4'b0, j_r};

  bsfd_ram #(
    .WIDTH (8),
    .DEPTH (bsfd_pkg::FRAME_LEN)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r),
    .wr_data (in_data_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Scale the assembled bytes of the current field
  always_comb begin
    mul_in = acc_r;
    unique case (desc.kind)
      bsfd_pkg::K_VOLT: mul_k = bsfd_pkg::SCALE_VOLT;
      bsfd_pkg::K_CAP:  mul_k = bsfd_pkg::SCALE_CAP;
      bsfd_pkg::K_CUR:  mul_k = bsfd_pkg::SCALE_CUR;
      bsfd_pkg::K_TEMP: mul_k = bsfd_pkg::SCALE_TEMP;
      default:          mul_k = bsfd_pkg::SCALE_ONE;
    endcase
    if (desc.kind == bsfd_pkg::K_CUR) begin
      mul_in = {8'b0, acc_r[15:0]};
    end
  end

  assign prod   = 34'(mul_in) * 34'(mul_k);
  assign scaled = prod[27:0];

  always_comb begin
    unique case (desc.kind)
      bsfd_pkg::K_TEMP: field_val = scaled - bsfd_pkg::TEMP_OFFSET;
      bsfd_pkg::K_FLAG: field_val = {20'b0, acc_r[7:0] & bsfd_pkg::FLAG_MASK};
      bsfd_pkg::K_CUR: begin
        priority if (acc_r[23:16] == bsfd_pkg::SIGN_ZERO) begin
          field_val = '0;
        end else if (acc_r[23:16] == bsfd_pkg::SIGN_MINUS) begin
          field_val = 28'd0 - scaled;
        end else begin
          field_val = scaled;
        end
      end
      default:          field_val = scaled;
    endcase
  end

  assign el_inc = (el_r == bsfd_pkg::ELAPSED_MAX) ? el_r : el_r + 17'd1;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    sum_nxt          = sum_r;
    el_nxt           = el_r;
    fld_nxt          = fld_r;
    j_nxt            = j_r;
    acc_nxt          = acc_r;
    rd_pend_nxt      = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_field_id_nxt = out_field_id_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;

    // shift in the byte read last cycle
    if (rd_pend_r) begin
      acc_nxt = {acc_r[15:0], ram_rdata};
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == bsfd_pkg::OP_TICK) begin
            el_nxt = el_inc;
            if (el_inc > {1'b0, timeout_r}) begin
              cnt_nxt          = '0;
              sum_nxt          = '0;
              el_nxt           = '0;
              out_valid_nxt    = 1'b1;
              out_status_nxt   = bsfd_pkg::STAT_TIMEOUT;
              out_field_id_nxt = '0;
              out_value_nxt    = '0;
              out_last_nxt     = 1'b1;
            end
          end else if (cnt_r == bsfd_pkg::LAST_BYTE_IDX) begin
            cnt_nxt = '0;
            sum_nxt = '0;
            el_nxt  = '0;
            if (sum_r != in_data_byte) begin
              out_valid_nxt    = 1'b1;
              out_status_nxt   = bsfd_pkg::STAT_CSUM;
              out_field_id_nxt = '0;
              out_value_nxt    = '0;
              out_last_nxt     = 1'b1;
            end else begin
              state_nxt = ST_READ;
              fld_nxt   = '0;
              j_nxt     = '0;
              acc_nxt   = '0;
            end
          end else begin
            cnt_nxt = cnt_r + 6'd1;
            sum_nxt = sum_r + in_data_byte;
          end
        end
      end
      ST_READ: begin
        rd_pend_nxt = 1'b1;
        if (j_r == desc.len - 2'd1) begin
          state_nxt = ST_LAST;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_LAST: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = bsfd_pkg::STAT_OK;
          out_field_id_nxt = fld_r;
          out_value_nxt    = field_val;
          out_last_nxt     = (fld_r == bsfd_pkg::LAST_FIELD);
          if (fld_r == bsfd_pkg::LAST_FIELD) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
            fld_nxt   = fld_r + 5'd1;
            j_nxt     = '0;
            acc_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timeout_r   <= bsfd_pkg::TIMEOUT_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      el_r        <= '0;
      fld_r       <= '0;
      j_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      el_r        <= el_nxt;
      fld_r       <= fld_nxt;
      j_r         <= j_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r          <= acc_nxt;
    out_status_r   <= out_status_nxt;
    out_field_id_r <= out_field_id_nxt;
    out_value_r    <= out_value_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_field_id = out_field_id_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/bsfd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bsfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
